// ----- sv/jse_pkg.sv -----
// Shared types, constants and byte-level helpers for the JSON string escaper.
`default_nettype none

package jse_pkg;

  // Fixed field widths
  localparam int BYTE_W  = 8;
  localparam int TOTAL_W = 16;
  localparam int CAP_W   = 16;
  localparam int LEN_W   = 3;

  // Escape room test and capacity reset value
  localparam logic [LEN_W-1:0] ESC_ROOM  = 3'd6;
  localparam logic [CAP_W-1:0] CAP_RESET = 16'd4096;

  // Queue between the front and the back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // Characters used by escape sequences
  localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
  localparam logic [BYTE_W-1:0] CH_BSL   = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_BS    = 8'h08;
  localparam logic [BYTE_W-1:0] CH_FF    = 8'h0C;
  localparam logic [BYTE_W-1:0] CH_N     = 8'h6E;
  localparam logic [BYTE_W-1:0] CH_R     = 8'h72;
  localparam logic [BYTE_W-1:0] CH_T     = 8'h74;
  localparam logic [BYTE_W-1:0] CH_B     = 8'h62;
  localparam logic [BYTE_W-1:0] CH_F     = 8'h66;
  localparam logic [BYTE_W-1:0] CH_U     = 8'h75;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_A     = 8'h61;
  localparam logic [BYTE_W-1:0] CTRL_LIMIT = 8'h20;

  // Input beat
  typedef struct packed {
    logic [BYTE_W-1:0] in_byte;
    logic              last_in;
  } in_beat_t;

  // Output beat
  typedef struct packed {
    logic [BYTE_W-1:0]  out_byte;
    logic               run_last;
    logic               dropped;
    logic [TOTAL_W-1:0] total_written;
    logic               string_done;
  } out_beat_t;

  // How an accepted byte expands
  typedef enum logic [1:0] {
    KIND_PLAIN,
    KIND_SHORT,
    KIND_UNI,
    KIND_DROP
  } esc_kind_t;

  // Classified item passed from front to back
  typedef struct packed {
    esc_kind_t         kind;
    logic [BYTE_W-1:0] sym;   // raw byte, or the escape letter for short escapes
    logic              last;
  } esc_item_t;

  // Number of output beats for each kind
  function automatic logic [LEN_W-1:0] esc_len(input esc_kind_t kind);
    logic [LEN_W-1:0] len;
    unique case (kind)
      KIND_PLAIN: len = 3'd1;
      KIND_SHORT: len = 3'd2;
      KIND_UNI:   len = 3'd6;
      KIND_DROP:  len = 3'd1;
    endcase
    return len;
  endfunction

  // Lower-case hex digit of a nibble
  function automatic logic [BYTE_W-1:0] hex_digit(input logic [3:0] v);
    logic [BYTE_W-1:0] d;
    if (v < 4'd10) begin
      d = CH_ZERO + BYTE_W'(v);
    end else begin
      d = CH_A + BYTE_W'(v - 4'd10);
    end
    return d;
  endfunction

  // Byte at position idx of the escaped form
  function automatic logic [BYTE_W-1:0] esc_beat(input esc_kind_t kind,
                                                 input logic [BYTE_W-1:0] sym,
                                                 input logic [LEN_W-1:0] idx);
    logic [BYTE_W-1:0] b;
    b = '0;
    unique case (kind)
      KIND_PLAIN: b = sym;
      KIND_SHORT: b = (idx == 3'd0) ? CH_BSL : sym;
      KIND_UNI: begin
        case (idx)
          3'd0:    b = CH_BSL;
          3'd1:    b = CH_U;
          3'd2:    b = CH_ZERO;
          3'd3:    b = CH_ZERO;
          3'd4:    b = hex_digit(sym[7:4]);
          default: b = hex_digit(sym[3:0]);
        endcase
      end
      KIND_DROP:  b = '0;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ----- sv/jse_front.sv -----
// Front end: capacity register, running count, room test and byte classification.
`default_nettype none

module jse_front import jse_pkg::*; #(
  parameter int COUNT_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CAP_W-1:0]      cfg_wr_data,
  input  wire in_beat_t              in_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  q_full,
  output logic                       q_push,
  output esc_item_t                  q_item,
  output logic [COUNT_BITS-1:0]      q_base
);

  localparam int RW = ((COUNT_BITS > CAP_W) ? COUNT_BITS : CAP_W) + 1;

  logic [CAP_W-1:0]      out_capacity;
  logic [COUNT_BITS-1:0] written_count;
  logic [COUNT_BITS-1:0] written_count_next;
  logic [RW-1:0]         room_sum;
  logic                  no_room;
  esc_kind_t             kind;
  logic [BYTE_W-1:0]     sym;

  // Capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_capacity <= CAP_RESET;
    end else if (cfg_wr_en) begin
      out_capacity <= cfg_wr_data;
    end
  end

  // Room test on the count, without overflow
  assign room_sum = RW'(written_count) + RW'(ESC_ROOM);
  assign no_room  = room_sum >= RW'(out_capacity);

  // Classify the incoming byte
  always_comb begin
    kind = KIND_SHORT;
    sym  = in_data.in_byte;
    unique case (in_data.in_byte)
      CH_QUOTE: sym = CH_QUOTE;
      CH_BSL:   sym = CH_BSL;
      CH_LF:    sym = CH_N;
      CH_CR:    sym = CH_R;
      CH_TAB:   sym = CH_T;
      CH_BS:    sym = CH_B;
      CH_FF:    sym = CH_F;
      default: begin
        kind = (in_data.in_byte < CTRL_LIMIT) ? KIND_UNI : KIND_PLAIN;
      end
    endcase
    if (no_room) begin
      kind = KIND_DROP;
    end
  end

  // Push into the queue
  assign in_stall    = q_full;
  assign q_push      = in_valid && !q_full;
  assign q_item.kind = kind;
  assign q_item.sym  = sym;
  assign q_item.last = in_data.last_in;
  assign q_base      = written_count;

  // Count advances by the escape length; clears after the last byte
  always_comb begin
    written_count_next = written_count;
    if (q_push) begin
      if (in_data.last_in) begin
        written_count_next = '0;
      end else if (!no_room) begin
        written_count_next = written_count + COUNT_BITS'(esc_len(kind));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written_count <= '0;
    end else begin
      written_count <= written_count_next;
    end
  end

endmodule

`default_nettype wire

// ----- sv/jse_queue.sv -----
// Small register queue of classified items between front and back.
`default_nettype none

module jse_queue import jse_pkg::*; #(
  parameter int COUNT_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire esc_item_t             push_item,
  input  wire logic [COUNT_BITS-1:0] push_base,
  input  wire logic                  pop,
  output logic                       full,
  output logic                       empty,
  output esc_item_t                  head_item,
  output logic [COUNT_BITS-1:0]      head_base
);

  esc_item_t             items [QDEPTH];
  logic [COUNT_BITS-1:0] bases [QDEPTH];
  logic [QPTR_W-1:0]     wr_ptr;
  logic [QPTR_W-1:0]     rd_ptr;
  logic [QCNT_W-1:0]     level;
  logic                  do_push;
  logic                  do_pop;

  assign full      = level == QCNT_W'(QDEPTH);
  assign empty     = level == '0;
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign head_item = items[rd_ptr];
  assign head_base = bases[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      items[wr_ptr] <= push_item;
      bases[wr_ptr] <= push_base;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   level <= level + 1'b1;
        2'b01:   level <= level - 1'b1;
        default: level <= level;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- sv/jse_back.sv -----
// Back end: walks the head item one output byte per cycle, unless stalled, into the output register.
`default_nettype none

module jse_back import jse_pkg::*; #(
  parameter int COUNT_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  q_empty,
  input  wire esc_item_t             q_item,
  input  wire logic [COUNT_BITS-1:0] q_base,
  output logic                       q_pop,
  output out_beat_t                  out_data,
  output logic                       out_valid,
  input  wire logic                  out_stall
);

  localparam int OW = (COUNT_BITS > TOTAL_W) ? COUNT_BITS : TOTAL_W;

  logic [LEN_W-1:0]      idx;
  logic [LEN_W-1:0]      len;
  logic                  final_beat;
  logic                  advance;
  logic [COUNT_BITS-1:0] cnt_now;
  logic [OW-1:0]         cnt_wide;
  out_beat_t             beat;

  assign len        = esc_len(q_item.kind);
  assign final_beat = idx == (len - 3'd1);
  assign advance    = !q_empty && (!out_valid || !out_stall);
  assign q_pop      = advance && final_beat;

  // Count seen by this beat
  always_comb begin
    if (q_item.kind == KIND_DROP) begin
      cnt_now = q_base;
    end else begin
      cnt_now = q_base + COUNT_BITS'(idx) + COUNT_BITS'(1);
    end
  end
  assign cnt_wide = OW'(cnt_now);

  // Build the beat
  always_comb begin
    beat.out_byte      = esc_beat(q_item.kind, q_item.sym, idx);
    beat.run_last      = final_beat;
    beat.dropped       = q_item.kind == KIND_DROP;
    beat.total_written = cnt_wide[TOTAL_W-1:0];
    beat.string_done   = final_beat && q_item.last;
  end

  // Beat index within the head item
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (advance) begin
      idx <= final_beat ? '0 : idx + 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= beat;
    end
  end

endmodule

`default_nettype wire

// ----- sv/json_string_escaper_top.sv -----
// Path: an accepted byte is queued; its beats are then held in the output register.
// Throughput: one plain input byte per cycle while the queue is not full; short escapes
//   give 2 output bytes and control-byte escapes 6, one per cycle while not stalled;
//   a 4-entry queue lets the input keep running while an escape drains.
// Reset (synchronous): count and queue clear, output empty, capacity back to 4096.
`default_nettype none

module json_string_escaper_top import jse_pkg::*; #(
  parameter int COUNT_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_wr_en,
  input  wire logic [CAP_W-1:0]  cfg_wr_data,
  input  wire in_beat_t          in_data,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output out_beat_t              out_data,
  output logic                   out_valid,
  input  wire logic              out_stall
);

  logic                  q_full;
  logic                  q_empty;
  logic                  q_push;
  logic                  q_pop;
  esc_item_t             push_item;
  esc_item_t             head_item;
  logic [COUNT_BITS-1:0] push_base;
  logic [COUNT_BITS-1:0] head_base;

  jse_front #(.COUNT_BITS(COUNT_BITS)) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (in_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_item      (push_item),
    .q_base      (push_base)
  );

  jse_queue #(.COUNT_BITS(COUNT_BITS)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .push_base (push_base),
    .pop       (q_pop),
    .full      (q_full),
    .empty     (q_empty),
    .head_item (head_item),
    .head_base (head_base)
  );

  jse_back #(.COUNT_BITS(COUNT_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_item    (head_item),
    .q_base    (head_base),
    .q_pop     (q_pop),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_stall (out_stall)
  );

  // A dropped beat is always a lone, zero-byte beat
  a_drop_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.dropped |-> out_data.run_last && out_data.out_byte == '0)
    else $error("dropped beat not a single zero beat");

  // String end only on the final beat of an item
  a_done_final: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.string_done |-> out_data.run_last)
    else $error("string_done on a non-final beat");

  // Queue never popped while empty
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("queue popped while empty");

  // Input is held off exactly while the queue is full
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !(q_empty && $past(q_full)))
    else $error("accepted into a full queue");

endmodule

`default_nettype wire

// ----- sim/json_string_escaper_top_tb.sv -----
// Self-checking testbench for the JSON string escaper: random strings, capacity sweeps, back-pressure.
`timescale 1ns / 100ps

module json_string_escaper_top_tb;
  import jse_pkg::*;

  localparam int COUNT_BITS = 16;
  localparam int HOLD_CYCLES = 200;
  localparam int SETTLE_CYCLES = 10;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_wr_en = 1'b0;
  logic [CAP_W-1:0] cfg_wr_data = '0;
  in_beat_t         in_data = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  out_beat_t        out_data;
  logic             out_valid;
  logic             out_stall = 1'b0;

  json_string_escaper_top #(.COUNT_BITS(COUNT_BITS)) DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (in_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_data    (out_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall)
  );

  // Clock, 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bytes waiting to be offered, escaped beats waiting to come out
  in_beat_t  pending_bytes[$];
  out_beat_t expected_beats[$];

  // Shadow of the block's string count and capacity register
  logic [COUNT_BITS-1:0] str_count = '0;
  logic [CAP_W-1:0]      cap_shadow = CAP_RESET;

  int send_idle = 0;
  int recv_idle = 0;
  int errors = 0;
  logic hold_req = 1'b0;
  int   hold_left = 0;

  function automatic logic [BYTE_W-1:0] nibble_char(input logic [3:0] n);
    if (n < 4'd10) begin
      return CH_ZERO + BYTE_W'(n);
    end
    return CH_A + BYTE_W'(n) - 8'd10;
  endfunction

  // Escape one accepted byte and queue the beats it should produce
  task automatic escape_and_count(input in_beat_t b);
    logic [BYTE_W-1:0] seq[6];
    logic [BYTE_W-1:0] letter;
    int n;
    out_beat_t r;
    letter = '0;
    if (int'(str_count) + int'(ESC_ROOM) >= int'(cap_shadow)) begin
      // no room: one dropped beat, count untouched
      r.out_byte = '0;
      r.run_last = 1'b1;
      r.dropped = 1'b1;
      r.total_written = TOTAL_W'(str_count);
      r.string_done = b.last_in;
      expected_beats.push_back(r);
    end else begin
      case (b.in_byte)
        CH_QUOTE: letter = CH_QUOTE;
        CH_BSL:   letter = CH_BSL;
        CH_LF:    letter = CH_N;
        CH_CR:    letter = CH_R;
        CH_TAB:   letter = CH_T;
        CH_BS:    letter = CH_B;
        CH_FF:    letter = CH_F;
        default:  letter = '0;
      endcase
      if (letter != '0) begin
        seq[0] = CH_BSL;
        seq[1] = letter;
        n = 2;
      end else if (b.in_byte < CTRL_LIMIT) begin
        seq[0] = CH_BSL;
        seq[1] = CH_U;
        seq[2] = CH_ZERO;
        seq[3] = CH_ZERO;
        seq[4] = nibble_char(b.in_byte[7:4]);
        seq[5] = nibble_char(b.in_byte[3:0]);
        n = 6;
      end else begin
        seq[0] = b.in_byte;
        n = 1;
      end
      for (int k = 0; k < n; k++) begin
        str_count = str_count + 1'b1;
        r.out_byte = seq[k];
        r.run_last = (k == n - 1);
        r.dropped = 1'b0;
        r.total_written = TOTAL_W'(str_count);
        r.string_done = (k == n - 1) && b.last_in;
        expected_beats.push_back(r);
      end
    end
    if (b.last_in) begin
      str_count = '0;
    end
  endtask

  // Driver: offer pending bytes, hold a stalled beat steady
  always @(posedge clk) begin
    in_beat_t nxt_data;
    logic     nxt_valid;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      nxt_valid = in_valid;
      nxt_data = in_data;
      if (in_valid && !in_stall) begin
        escape_and_count(in_data);
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && pending_bytes.size() != 0 && $urandom_range(99) >= send_idle) begin
        nxt_data = pending_bytes.pop_front();
        nxt_valid = 1'b1;
      end
      in_valid <= nxt_valid;
      in_data <= nxt_data;
    end
  end

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  // Monitor: compare each output beat with the oldest expected one
  always @(posedge clk) begin
    out_beat_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_beats.size() == 0) begin
          $display("%0t: unexpected beat: expected none, actual %h", $time, out_data);
          errors++;
        end else begin
          want = expected_beats.pop_front();
          check_field("out_byte", 16'(want.out_byte), 16'(out_data.out_byte));
          check_field("run_last", 16'(want.run_last), 16'(out_data.run_last));
          check_field("dropped", 16'(want.dropped), 16'(out_data.dropped));
          check_field("total_written", want.total_written, out_data.total_written);
          check_field("string_done", 16'(want.string_done), 16'(out_data.string_done));
        end
      end
      out_stall <= (hold_left > 0) || ($urandom_range(99) < recv_idle);
    end
  end

  // Long receiver hold-off, counted here
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_req) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  task automatic push_byte(input logic [BYTE_W-1:0] v, input logic last);
    in_beat_t b;
    b.in_byte = v;
    b.last_in = last;
    pending_bytes.push_back(b);
  endtask

  // Mix of printable, short-escape, control and fully random bytes
  function automatic logic [BYTE_W-1:0] pick_byte();
    logic [BYTE_W-1:0] specials[7];
    specials = '{CH_QUOTE, CH_BSL, CH_LF, CH_CR, CH_TAB, CH_BS, CH_FF};
    case ($urandom_range(9))
      0, 1, 2, 3: return BYTE_W'($urandom_range(8'h7e, 8'h20));
      4, 5:       return specials[$urandom_range(6)];
      6, 7:       return BYTE_W'($urandom_range(8'h1f, 0));
      default:    return BYTE_W'($urandom_range(255));
    endcase
  endfunction

  // Queue whole strings until the byte budget is spent; a few are left open
  task automatic queue_strings(input int budget, input int max_len);
    int len;
    bit open_end;
    while (budget > 0) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(max_len, 1) : $urandom_range(8, 1);
      if (len > budget) begin
        len = budget;
      end
      open_end = ($urandom_range(9) == 0);
      for (int i = 0; i < len; i++) begin
        push_byte(pick_byte(), (i == len - 1) && !open_end);
      end
      budget -= len;
    end
  endtask

  // Wait until the block has nothing in flight
  task automatic drain();
    while (pending_bytes.size() != 0 || in_valid || expected_beats.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    cap_shadow = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_phase(input logic [CAP_W-1:0] cap, input int s_idle, input int r_idle,
                           input int budget, input int max_len, input bit squeeze);
    drain();
    write_capacity(cap);
    send_idle <= s_idle;
    recv_idle <= r_idle;
    queue_strings(budget, max_len);
    if (squeeze) begin
      hold_req <= 1'b1;
      @(posedge clk);
      hold_req <= 1'b0;
    end
  endtask

  // Sequence of phases
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: every escape class and byte extremes at reset capacity
    push_byte(8'h00, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(CH_BS, 1'b0);
    push_byte(CH_TAB, 1'b0);
    push_byte(CH_LF, 1'b0);
    push_byte(CH_FF, 1'b0);
    push_byte(CH_CR, 1'b0);
    push_byte(8'h1a, 1'b0);
    push_byte(8'h1f, 1'b0);
    push_byte(8'h20, 1'b0);
    push_byte(CH_QUOTE, 1'b0);
    push_byte(CH_BSL, 1'b0);
    push_byte(8'h41, 1'b0);
    push_byte(8'h7f, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'hff, 1'b1);
    push_byte(CH_LF, 1'b1);

    // directed: small capacity, refusal, clear after a refused last byte, exact fit
    drain();
    write_capacity(16'd8);
    push_byte(8'h61, 1'b0);
    push_byte(8'h62, 1'b0);
    push_byte(8'h63, 1'b0);
    push_byte(8'h64, 1'b1);
    push_byte(8'h65, 1'b1);
    push_byte(8'h01, 1'b1);

    // random phases over capacities and idling patterns
    run_phase(16'd0, 0, 0, 15, 8, 1'b0);
    run_phase(16'hffff, 72, 0, 70, 40, 1'b0);
    run_phase(16'd30, 0, 72, 70, 20, 1'b0);
    run_phase(16'd60, 30, 30, 70, 30, 1'b0);
    run_phase(16'd4096, 0, 0, 60, 40, 1'b1);
    run_phase(16'd7, 30, 30, 60, 10, 1'b0);

    drain();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- sim.f -----
sv/jse_pkg.sv
sv/jse_front.sv
sv/jse_queue.sv
sv/jse_back.sv
sv/json_string_escaper_top.sv
sim/json_string_escaper_top_tb.sv
